### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the sphere mesh index generator. Each macro checks
// on the rising edge of clk and is off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SMIG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smig assertion failed");

// Next-cycle implication.
`define SMIG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smig assertion failed");

`else

`define SMIG_ASSERT_IMP(lbl, ante, cons)
`define SMIG_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### sv/smig_pkg.sv
// ----------------------------------------------------------------------------
// smig_pkg
// Shared constants and types of the sphere mesh index generator.
// ----------------------------------------------------------------------------
package smig_pkg;

  // Vertex index width of one triangle corner.
  localparam int IDX_W = 15;

  // Width of the subdivision register.
  localparam int CFG_W = 7;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_IDX_SUBDIV = 1'b0;

  // Default and upper bound of the subdivision count.
  localparam int MAX_SUBDIVISIONS_DEF = 64;
  localparam logic [CFG_W-1:0] SUBDIV_RESET = CFG_W'(1);

  // Part of the index list being generated.
  typedef enum logic [2:0] {
    PH_BAND = 3'b001,
    PH_BOT  = 3'b010,
    PH_TOP  = 3'b100
  } phase_t;

  // One emitted triangle.
  typedef struct packed {
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic [IDX_W-1:0] third;
    logic             last;
  } tri_t;

endpackage

### sv/sphere_mesh_index_generator.sv
// ----------------------------------------------------------------------------
// A triangle is registered into the output slot, or the skid slot if that one is held.
// One triangle per cycle while in_stall is low; the counters and a running ring base
// advance on each accepted request, and a skid register absorbs one output stall.
// Reset (rst_n low, synchronous): subdivisions returns to 1, the sequence to
// its first triangle, and both output slots empty.
// ----------------------------------------------------------------------------
// sphere_mesh_index_generator
// Emits the triangle index list of a latitude-longitude sphere, one triangle
// per request: ring bands, then the bottom cap fan, then the top cap fan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sphere_mesh_index_generator
  import smig_pkg::*;
#(
  parameter int MAX_SUBDIVISIONS = MAX_SUBDIVISIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_restart,
  // Triangle channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_W-1:0]      out_first_index,
  output logic [IDX_W-1:0]      out_second_index,
  output logic [IDX_W-1:0]      out_third_index,
  output logic                  out_last_triangle,
  // Configuration port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int SW = $clog2(MAX_SUBDIVISIONS + 1);
  localparam int RW = $clog2(2 * MAX_SUBDIVISIONS);
  localparam int GW = $clog2(4 * MAX_SUBDIVISIONS + 1);

  // Sphere dimensions that follow from the subdivision count.
  typedef struct packed {
    logic [GW-1:0]    segs;
    logic [RW-1:0]    pairs;
    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] tbase;
  } geom_t;

  function automatic geom_t derive_geom(input logic [CFG_W-1:0] s_raw);
    logic [SW-1:0]    s_eff;
    logic [IDX_W-1:0] rings;
    geom_t            g;
    if (s_raw == '0) begin
      s_eff = SW'(1);
    end else if (s_raw > CFG_W'(MAX_SUBDIVISIONS)) begin
      s_eff = SW'(MAX_SUBDIVISIONS);
    end else begin
      s_eff = SW'(s_raw);
    end
    g.segs  = GW'(s_eff) << 2;
    g.pairs = RW'((RW + 1)'(s_eff) * (RW + 1)'(2) - (RW + 1)'(2));
    rings   = IDX_W'(s_eff) * IDX_W'(2) - IDX_W'(1);
    g.top   = rings * IDX_W'(g.segs) + IDX_W'(1);
    g.tbase = g.top - IDX_W'(g.segs);
    return g;
  endfunction

  // Configuration and sequence state.
  logic [CFG_W-1:0] subdiv_r;
  geom_t            geom_r;
  phase_t           phase_r, phase_nxt;
  logic [RW-1:0]    ring_r, ring_nxt;
  logic [GW-1:0]    seg_r, seg_nxt;
  logic             half_r, half_nxt;
  logic [IDX_W-1:0] abase_r, abase_nxt;

  // Output register and skid register.
  logic             out_valid_r, skid_valid_r;
  tri_t             out_tri_r, skid_tri_r;
  tri_t             tri_nxt;

  logic             in_acc, out_take, cfg_wr;

  assign in_stall   = skid_valid_r;
  assign in_acc     = in_valid && !in_stall;
  assign out_take   = out_valid_r && !out_stall;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  // Register read-back.
  always_comb begin
    if (cfg_paddr[2] == CFG_IDX_SUBDIV) begin
      cfg_prdata = CFG_DATA_W'(subdiv_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  // Triangle for the current request and the advanced counters.
  always_comb begin
    phase_t           ph;
    logic [RW-1:0]    rg;
    logic [GW-1:0]    sg;
    logic             hf;
    logic [IDX_W-1:0] ab;
    logic [GW-1:0]    prev;
    logic [IDX_W-1:0] bb;
    logic [GW:0]      sg_inc;
    logic [RW:0]      rg_inc;

    ph = phase_r;
    rg = ring_r;
    sg = seg_r;
    hf = half_r;
    ab = abase_r;
    if (in_restart) begin
      ph = PH_BAND;
      rg = '0;
      sg = '0;
      hf = 1'b0;
      ab = IDX_W'(1);
    end
    // Without ring pairs the band part is skipped.
    if (ph == PH_BAND && rg >= geom_r.pairs) begin
      ph = PH_BOT;
      rg = '0;
      sg = '0;
      hf = 1'b0;
      ab = IDX_W'(1);
    end
    if (sg >= geom_r.segs) begin
      sg = '0;
    end

    prev = (sg == '0) ? geom_r.segs - GW'(1) : sg - GW'(1);
    bb   = ab + IDX_W'(geom_r.segs);

    tri_nxt.last = 1'b0;
    unique case (ph)
      PH_BAND: begin
        if (!hf) begin
          tri_nxt.first  = ab + IDX_W'(prev);
          tri_nxt.second = ab + IDX_W'(sg);
          tri_nxt.third  = bb + IDX_W'(sg);
        end else begin
          tri_nxt.first  = bb + IDX_W'(sg);
          tri_nxt.second = bb + IDX_W'(prev);
          tri_nxt.third  = ab + IDX_W'(prev);
        end
      end
      PH_BOT: begin
        tri_nxt.first  = IDX_W'(1) + IDX_W'(sg);
        tri_nxt.second = IDX_W'(1) + IDX_W'(prev);
        tri_nxt.third  = '0;
      end
      default: begin
        tri_nxt.first  = geom_r.tbase + IDX_W'(prev);
        tri_nxt.second = geom_r.tbase + IDX_W'(sg);
        tri_nxt.third  = geom_r.top;
        tri_nxt.last   = (sg == geom_r.segs - GW'(1));
      end
    endcase

    // Advance to the next triangle.
    sg_inc    = {1'b0, sg} + (GW + 1)'(1);
    rg_inc    = {1'b0, rg} + (RW + 1)'(1);
    phase_nxt = ph;
    ring_nxt  = rg;
    seg_nxt   = sg;
    half_nxt  = hf;
    abase_nxt = ab;
    if (ph == PH_BAND) begin
      if (!hf) begin
        half_nxt = 1'b1;
      end else begin
        half_nxt = 1'b0;
        if (sg_inc >= {1'b0, geom_r.segs}) begin
          seg_nxt = '0;
          if (rg_inc >= {1'b0, geom_r.pairs}) begin
            ring_nxt  = '0;
            abase_nxt = IDX_W'(1);
            phase_nxt = PH_BOT;
          end else begin
            ring_nxt  = rg_inc[RW-1:0];
            abase_nxt = bb;
          end
        end else begin
          seg_nxt = sg_inc[GW-1:0];
        end
      end
    end else if (sg_inc >= {1'b0, geom_r.segs}) begin
      seg_nxt = '0;
      if (ph == PH_BOT) begin
        phase_nxt = PH_TOP;
      end else begin
        phase_nxt = PH_BAND;
        ring_nxt  = '0;
        half_nxt  = 1'b0;
        abase_nxt = IDX_W'(1);
      end
    end else begin
      seg_nxt = sg_inc[GW-1:0];
    end
  end

  // Configuration and sequence registers; a register write restarts the list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subdiv_r <= SUBDIV_RESET;
      geom_r   <= derive_geom(SUBDIV_RESET);
      phase_r  <= PH_BAND;
      ring_r   <= '0;
      seg_r    <= '0;
      half_r   <= 1'b0;
      abase_r  <= IDX_W'(1);
    end else if (cfg_wr && cfg_paddr[2] == CFG_IDX_SUBDIV) begin
      subdiv_r <= cfg_pwdata[CFG_W-1:0];
      geom_r   <= derive_geom(cfg_pwdata[CFG_W-1:0]);
      phase_r  <= PH_BAND;
      ring_r   <= '0;
      seg_r    <= '0;
      half_r   <= 1'b0;
      abase_r  <= IDX_W'(1);
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      ring_r   <= ring_nxt;
      seg_r    <= seg_nxt;
      half_r   <= half_nxt;
      abase_r  <= abase_nxt;
    end
  end

  // Output slot and skid slot valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output slot and skid slot payload.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_tri_r <= skid_tri_r;
      end
    end else if (in_acc) begin
      if (out_valid_r && !out_take) begin
        skid_tri_r <= tri_nxt;
      end else begin
        out_tri_r <= tri_nxt;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_first_index   = out_tri_r.first;
  assign out_second_index  = out_tri_r.second;
  assign out_third_index   = out_tri_r.third;
  assign out_last_triangle = out_tri_r.last;

  // The skid slot only fills behind an occupied output slot.
  `SMIG_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r)
  // A final triangle always closes on the top pole.
  `SMIG_ASSERT_IMP(a_last_on_pole, out_valid_r && out_tri_r.last,
                   out_tri_r.third == geom_r.top)
  // An accepted restart, with ring pairs and no register write, leaves the sequence on its second triangle.
  `SMIG_ASSERT_NXT(a_restart_moves, in_acc && in_restart && !cfg_wr && geom_r.pairs != '0,
                   phase_r == PH_BAND && half_r && ring_r == '0 && seg_r == '0)

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Sphere mesh index generator testbench
// Drives triangle requests with random bursts and gaps. The result side
// stalls on its own changing pattern, with one long hold-off. Every
// triangle is checked against a behavioral copy of the index list walker.
// The subdivision register is rewritten between phases, including the
// zero and saturating settings.
// ----------------------------------------------------------------------------
module testbench
  import smig_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] SUBDIV_ADDR = CFG_ADDR_W'(4 * CFG_IDX_SUBDIV);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_restart = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [IDX_W-1:0]      out_first_index;
  logic [IDX_W-1:0]      out_second_index;
  logic [IDX_W-1:0]      out_third_index;
  logic                  out_last_triangle;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  sphere_mesh_index_generator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_first_index   (out_first_index),
    .out_second_index  (out_second_index),
    .out_third_index   (out_third_index),
    .out_last_triangle (out_last_triangle),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  // Walker state mirroring the block's index list position.
  logic [CFG_W-1:0] subdiv_reg;
  phase_t           part_now;
  logic [6:0]       ring_cnt;
  logic [7:0]       seg_cnt;
  logic             quad_half;

  bit   request_q[$];
  tri_t triangle_q[$];
  tri_t head_tri;
  int   fail_count = 0;

  // Sender burst shaping and receiver stall pattern.
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int mode_left = 0;
  int stall_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void rewind_list();
    part_now = PH_BAND;
    ring_cnt = '0;
    seg_cnt = '0;
    quad_half = 1'b0;
  endfunction

  // Appends one request item to the pending queue.
  function automatic void add_request(input bit restart_req);
    request_q.insert(request_q.size(), restart_req);
  endfunction

  // Computes the triangle for one request and advances the walker.
  function automatic tri_t next_triangle(input logic restart);
    int s_eff, segs, pairs, verts, seg, prev, a, b, t;
    tri_t tri_out;
    s_eff = (subdiv_reg == '0) ? 1 : int'(subdiv_reg);
    if (s_eff > MAX_SUBDIVISIONS_DEF) s_eff = MAX_SUBDIVISIONS_DEF;
    segs = 4 * s_eff;
    pairs = 2 * s_eff - 2;
    verts = (2 * s_eff - 1) * segs + 2;
    if (restart) rewind_list();
    // With a single subdivision there are no ring bands at all.
    if (part_now == PH_BAND && int'(ring_cnt) >= pairs) begin
      part_now = PH_BOT;
      ring_cnt = '0;
      seg_cnt = '0;
      quad_half = 1'b0;
    end
    if (int'(seg_cnt) >= segs) seg_cnt = '0;
    seg = int'(seg_cnt);
    prev = (seg == 0) ? segs - 1 : seg - 1;
    tri_out.last = 1'b0;
    case (part_now)
      PH_BAND: begin
        a = 1 + int'(ring_cnt) * segs;
        b = a + segs;
        if (!quad_half) begin
          tri_out.first = IDX_W'(a + prev);
          tri_out.second = IDX_W'(a + seg);
          tri_out.third = IDX_W'(b + seg);
        end else begin
          tri_out.first = IDX_W'(b + seg);
          tri_out.second = IDX_W'(b + prev);
          tri_out.third = IDX_W'(a + prev);
        end
      end
      PH_BOT: begin
        tri_out.first = IDX_W'(1 + seg);
        tri_out.second = IDX_W'(1 + prev);
        tri_out.third = '0;
      end
      default: begin
        t = verts - 1 - segs;
        tri_out.first = IDX_W'(t + prev);
        tri_out.second = IDX_W'(t + seg);
        tri_out.third = IDX_W'(verts - 1);
        tri_out.last = (seg == segs - 1);
      end
    endcase
    // Advance; counters are compared in full width before they wrap.
    if (part_now == PH_BAND) begin
      if (!quad_half) begin
        quad_half = 1'b1;
      end else begin
        quad_half = 1'b0;
        if (seg + 1 >= segs) begin
          seg_cnt = '0;
          if (int'(ring_cnt) + 1 >= pairs) begin
            ring_cnt = '0;
            part_now = PH_BOT;
          end else begin
            ring_cnt = ring_cnt + 1'b1;
          end
        end else begin
          seg_cnt = seg_cnt + 1'b1;
        end
      end
    end else if (seg + 1 >= segs) begin
      seg_cnt = '0;
      if (part_now == PH_BOT) part_now = PH_TOP;
      else rewind_list();
    end else begin
      seg_cnt = seg_cnt + 1'b1;
    end
    return tri_out;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Request driver: bursts of items from the pending queue, with gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        triangle_q.insert(triangle_q.size(), next_triangle(in_restart));
      end
      if (in_valid && in_stall) begin
        // A stalled item stays as it is.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_valid <= 1'b1;
        in_restart <= request_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall pattern; a requested hold-off is counted down here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_done < holds_asked) begin
        hold_left = $urandom_range(150, 300);
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(16, 96);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 20;
            3: stall_pct = 50;
            default: stall_pct = 90;
          endcase
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Triangle monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (triangle_q.size() == 0) begin
        $error("unexpected triangle %0d %0d %0d", out_first_index, out_second_index,
               out_third_index);
        fail_count++;
      end else begin
        head_tri = triangle_q.pop_front();
        check_field("first_index", int'(head_tri.first), int'(out_first_index));
        check_field("second_index", int'(head_tri.second), int'(out_second_index));
        check_field("third_index", int'(head_tri.third), int'(out_third_index));
        check_field("last_triangle", int'(head_tri.last), int'(out_last_triangle));
      end
    end
  end

  // Waits until every item is sent and every triangle has come back.
  task automatic drain();
    while (request_q.size() != 0 || in_valid || triangle_q.size() != 0) @(negedge clk);
  endtask

  // Writes the subdivision count, then reads it back.
  task automatic write_subdivisions(input int sub_val);
    logic [CFG_DATA_W-1:0] word;
    word = ($urandom() << CFG_W) | CFG_DATA_W'(sub_val & 'h7F);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= SUBDIV_ADDR;
    cfg_pwdata <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    subdiv_reg = word[CFG_W-1:0];
    rewind_list();
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("subdivisions", int'(subdiv_reg), int'(cfg_prdata));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // One setting with a run of mostly continuing requests.
  task automatic run_phase(input int sub_val, input int count, input bit long_hold);
    write_subdivisions(sub_val);
    for (int i = 0; i < count; i++) begin
      if (i == 0) add_request(1'($urandom_range(0, 1)));
      else add_request($urandom_range(0, 149) == 0);
    end
    if (long_hold) holds_asked++;
    drain();
  endtask

  // Stimulus sequence.
  initial begin
    subdiv_reg = SUBDIV_RESET;
    rewind_list();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: walk the whole two-cap list, wrap, and restart midway.
    add_request(1'b1);
    repeat (11) add_request(1'b0);
    add_request(1'b1);
    repeat (3) add_request(1'b0);
    drain();

    // Zero subdivisions behave like one.
    write_subdivisions(0);
    add_request(1'b0);
    add_request(1'b0);
    add_request(1'b1);
    drain();

    // Largest register value saturates to the maximum.
    write_subdivisions(127);
    add_request(1'b0);
    add_request(1'b0);
    add_request(1'b1);
    drain();

    // Random phases; small sizes get through whole lists.
    run_phase(2, 120, 1'b0);
    run_phase(3, 200, 1'b0);
    run_phase(64, 80, 1'b0);
    run_phase(65, 40, 1'b0);
    run_phase(4, 260, 1'b1);
    run_phase(0, 30, 1'b0);
    run_phase(1, 40, 1'b0);
    run_phase($urandom_range(5, 8), 150, 1'b0);
    run_phase(127, 30, 1'b0);
    run_phase($urandom_range(1, 127), 60, 1'b0);

    repeat (5) @(posedge clk);
    if (triangle_q.size() != 0) begin
      $error("%0d triangles never arrived", triangle_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[sphere_mesh_index_generator] OK");
    end else begin
      $display("[sphere_mesh_index_generator] ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("[sphere_mesh_index_generator] ERROR");
    $finish;
  end

endmodule
